// File: src/actr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package actr_pkg;

    localparam int BLOCKS = 4;
    localparam int BLK_CNT_W = (BLOCKS > 1) ? $clog2(BLOCKS + 1) : 1;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_RESEED = 2'd1,
        FUNC_GEN    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [31:0] entropy_counter;
        logic [63:0] entropy_key_3;
        logic [63:0] entropy_key_2;
        logic [63:0] entropy_key_1;
        logic [63:0] entropy_key_0;
        logic [1:0]  func;
    } in_item_t;

    typedef struct packed {
        logic        last_block;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN_START,
        ST_GEN_WAIT,
        ST_GEN_OUT,
        ST_RS_START,
        ST_RS_WAIT,
        ST_RS_FINISH
    } ctl_state_t;

    // cipher core handshake
    typedef struct packed {
        logic start;
    } core_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// File: src/actr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// AES-256 encryption on a byte-serial datapath. The state is a
// 16-byte shift line; SubBytes+ShiftRows and AddRoundKey step one byte per
// cycle, MixColumns one column at a time. The key schedule steps one
// 4-byte word per cycle on a sliding 32-byte window of the last 8 words.
module actr_core
    import actr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire core_req_t    req,
    input  wire logic [255:0] key,
    input  wire logic [31:0]  ctr,
    output core_sts_t         sts,
    output logic [127:0]      result
);

    typedef enum logic [2:0] {
        C_IDLE, C_ARK, C_SUB, C_MIX, C_KEY, C_DONE
    } cstate_t;

    cstate_t      st_reg, st_next;
    logic [127:0] s_reg, s_next;     // byte 0 in [7:0]
    logic [127:0] t_reg, t_next;
    logic [255:0] rk_reg, rk_next;   // bytes 0..31 of current window
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [2:0]   wi_reg, wi_next;   // word index within 8-word group

    logic [3:0]  sb_src;
    logic [7:0]  sb_in;
    logic [31:0] w, col, mcol;
    logic [7:0]  a0, a1, a2, a3, al;

    always_comb
    begin
        // ShiftRows source byte for output position cnt (j = cnt%4, c = cnt/4)
        sb_src = {2'(cnt_reg[3:2] + cnt_reg[1:0]), cnt_reg[1:0]};
        sb_in  = s_reg[8*sb_src +: 8];
        w      = rk_reg[255:224];
        col    = t_reg[31:0];
        a0 = col[7:0]; a1 = col[15:8]; a2 = col[23:16]; a3 = col[31:24];
        al = a0 ^ a1 ^ a2 ^ a3;
        mcol = {a3 ^ al ^ xtime(a3 ^ a0), a2 ^ al ^ xtime(a2 ^ a3),
                a1 ^ al ^ xtime(a1 ^ a2), a0 ^ al ^ xtime(a0 ^ a1)};
        if (wi_reg == 3'd0)
            w = {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]),
                 sbox(w[15:8]) ^ rcon_reg};
        else if (wi_reg == 3'd4)
            w = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            C_IDLE: if (req.start) st_next = C_ARK;
            C_ARK:  if (cnt_reg == 5'd15)
                        st_next = (round_reg == 4'd14) ? C_DONE : C_KEY;
            C_KEY:  if (cnt_reg[1:0] == 2'd3) st_next = C_SUB;
            C_SUB:  if (cnt_reg == 5'd15)
                        st_next = (round_reg == 4'd14) ? C_ARK : C_MIX;
            C_MIX:  if (cnt_reg[1:0] == 2'd3) st_next = C_ARK;
            C_DONE: st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        s_next = s_reg; t_next = t_reg; rk_next = rk_reg; rcon_next = rcon_reg;
        round_next = round_reg; cnt_next = cnt_reg; wi_next = wi_reg;
        unique case (st_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    s_next = {4{ctr}};
                    rk_next = key; rcon_next = 8'h01;
                    round_next = 4'd0; cnt_next = 5'd0; wi_next = 3'd0;
                end
            end
            C_ARK:
            begin
                // round 0 keys from the low half, later rounds from the high half;
                // shift state down a byte and rotate only the half in use
                if (round_reg == 4'd0)
                begin
                    s_next = {s_reg[7:0] ^ rk_reg[7:0], s_reg[127:8]};
                    rk_next = {rk_reg[255:128], rk_reg[7:0], rk_reg[127:8]};
                end
                else
                begin
                    s_next = {s_reg[7:0] ^ rk_reg[135:128], s_reg[127:8]};
                    rk_next = {rk_reg[135:128], rk_reg[255:136], rk_reg[127:0]};
                end
                cnt_next = (cnt_reg == 5'd15) ? 5'd0 : 5'(cnt_reg + 5'd1);
                if (cnt_reg == 5'd15 && round_reg != 4'd14)
                    round_next = 4'(round_reg + 4'd1);
            end
            C_KEY:
            begin
                // from round 2 on, slide the window by one 4-word round key
                if (round_reg >= 4'd2)
                begin
                    rk_next = {rk_reg[31:0] ^ w, rk_reg[255:32]};
                    wi_next = 3'(wi_reg + 3'd1);
                    if (wi_reg == 3'd0) rcon_next = xtime(rcon_reg);
                end
                cnt_next = (cnt_reg[1:0] == 2'd3) ? 5'd0 : 5'(cnt_reg + 5'd1);
            end
            C_SUB:
            begin
                t_next = {sbox(sb_in), t_reg[127:8]};
                cnt_next = (cnt_reg == 5'd15) ? 5'd0 : 5'(cnt_reg + 5'd1);
                if (cnt_reg == 5'd15 && round_reg == 4'd14)
                    s_next = {sbox(sb_in), t_reg[127:8]};
            end
            C_MIX:
            begin
                t_next = {mcol, t_reg[127:32]};
                cnt_next = (cnt_reg[1:0] == 2'd3) ? 5'd0 : 5'(cnt_reg + 5'd1);
                if (cnt_reg[1:0] == 2'd3)
                    s_next = {mcol, t_reg[127:32]};
            end
            C_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE;
            cnt_reg <= '0;
            round_reg <= '0;
            wi_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            round_reg <= round_next;
            wi_reg <= wi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        t_reg <= t_next;
        rk_reg <= rk_next;
        rcon_reg <= rcon_next;
    end

    assign sts.busy = (st_reg != C_IDLE);
    assign sts.done = (st_reg == C_DONE);
    assign result   = s_reg;

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> !sts.done) else $error("done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == C_IDLE && req.start) |=> st_reg == C_ARK) else $error("no start");
    a_round: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= 4'd14) else $error("round overrun");

endmodule
`default_nettype wire

// File: src/aes256_ctr_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Signals                        Direction
// in       in_valid, in_stall, in_data    request in (func, entropy)
// out      out_valid, out_stall, out_data one result per generated block
// cfg      cfg_we, cfg_wdata              reseed interval
// One AES-256 block takes the initial key add and 14 rounds, all run by the
// byte-serial cipher core. Generate: BLOCKS encryptions; a reseed, due when
// the request count reaches the interval, adds three more. Load sets the
// key and clears the counter.
// Reset clears key, counter and request count and sets interval to 1024.
// A stalled output holds the core until the block is taken.
module aes256_ctr_random_generator
    import actr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    ctl_state_t st_reg, st_next;
    logic [255:0] key_reg;
    logic [31:0]  ctr_reg;
    logic [15:0]  rsc_reg, ival_reg;
    in_item_t     item_reg;
    logic [BLK_CNT_W-1:0] n_reg;
    logic [1:0]   rsn_reg;
    logic [383:0] buf_reg;          // A|B|C, byte 0 in [7:0]
    logic         ov_reg;
    out_item_t    od_reg;
    core_req_t    creq;
    core_sts_t    csts;
    logic [127:0] cres;
    logic         acc_in;
    logic [15:0]  rsc_inc;
    logic [31:0]  core_ctr;

    actr_core u_core (
        .clk(clk), .rst_n(rst_n), .req(creq), .key(key_reg),
        .ctr(core_ctr), .sts(csts), .result(cres)
    );

    assign acc_in  = in_valid && !in_stall;
    assign rsc_inc = 16'(rsc_reg + 16'd1);
    // reseed encrypts the pre-incremented counter
    assign core_ctr = (st_reg == ST_RS_START) ? 32'(ctr_reg + 32'd1) : ctr_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
                if (acc_in)
                begin
                    unique case (func_t'(in_data.func))
                        FUNC_GEN:    st_next = ST_GEN_START;
                        FUNC_RESEED: st_next = ST_RS_START;
                        default:     st_next = ST_IDLE;
                    endcase
                end
            ST_GEN_START: st_next = ST_GEN_WAIT;
            ST_GEN_WAIT:  if (csts.done) st_next = ST_GEN_OUT;
            ST_GEN_OUT:
                if (!ov_reg)
                begin
                    if (n_reg != BLK_CNT_W'(BLOCKS - 1)) st_next = ST_GEN_START;
                    else if (rsc_inc >= ival_reg) st_next = ST_RS_START;
                    else st_next = ST_IDLE;
                end
            ST_RS_START: st_next = ST_RS_WAIT;
            ST_RS_WAIT:
                if (csts.done) st_next = (rsn_reg == 2'd2) ? ST_RS_FINISH : ST_RS_START;
            ST_RS_FINISH: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        creq.start = (st_reg == ST_GEN_START) || (st_reg == ST_RS_START);
        in_stall   = (st_reg != ST_IDLE) || ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            key_reg <= '0;
            ctr_reg <= '0;
            rsc_reg <= '0;
            ival_reg <= 16'd1024;
            ov_reg <= 1'b0;
            n_reg <= '0;
            rsn_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we) ival_reg <= cfg_wdata;
            if (ov_reg && !out_stall) ov_reg <= 1'b0;
            if (st_reg == ST_IDLE && acc_in)
            begin
                n_reg <= '0;
                rsn_reg <= '0;
                if (func_t'(in_data.func) == FUNC_LOAD)
                begin
                    key_reg <= {in_data.entropy_key_3, in_data.entropy_key_2,
                                in_data.entropy_key_1, in_data.entropy_key_0};
                    ctr_reg <= '0;
                end
                if (func_t'(in_data.func) == FUNC_RESEED) rsc_reg <= '0;
            end
            if (st_reg == ST_GEN_WAIT && csts.done)
            begin
                ov_reg <= 1'b1;
                ctr_reg <= 32'(ctr_reg + 32'd1);
            end
            if (st_reg == ST_GEN_OUT && !ov_reg)
            begin
                n_reg <= BLK_CNT_W'(n_reg + 1'b1);
                if (n_reg == BLK_CNT_W'(BLOCKS - 1))
                begin
                    rsc_reg <= (rsc_inc >= ival_reg) ? 16'd0 : rsc_inc;
                    rsn_reg <= '0;
                end
            end
            // pre-increment ahead of each reseed encryption
            if (st_reg == ST_RS_START) ctr_reg <= 32'(ctr_reg + 32'd1);
            if (st_reg == ST_RS_WAIT && csts.done) rsn_reg <= 2'(rsn_reg + 2'd1);
            if (st_reg == ST_RS_FINISH)
            begin
                key_reg <= {item_reg.entropy_key_3, item_reg.entropy_key_2,
                            item_reg.entropy_key_1, item_reg.entropy_key_0}
                           ^ buf_reg[351:96];
                ctr_reg <= ctr_reg ^ item_reg.entropy_counter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && acc_in) item_reg <= in_data;
        if (st_reg == ST_GEN_WAIT && csts.done)
        begin
            od_reg.block_low  <= cres[63:0];
            od_reg.block_high <= cres[127:64];
            od_reg.last_block <= (n_reg == BLK_CNT_W'(BLOCKS - 1));
        end
        // first result ends up in the top (A), last in the bottom (C)
        if (st_reg == ST_RS_WAIT && csts.done)
            buf_reg <= {buf_reg[255:0], cres};
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken with result pending");
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_RS_START) |=> ctr_reg == 32'($past(ctr_reg) + 32'd1))
        else $error("counter step");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        creq.start |-> !csts.busy) else $error("core restarted");

endmodule
`default_nettype wire
